// ===== hdl/uart_8e1_with_rx_fifo_unit_assert.svh =====
// Assertion macros for the UART 8E1 unit with receive ring.
`ifndef UART_8E1_WITH_RX_FIFO_UNIT_ASSERT_SVH
`define UART_8E1_WITH_RX_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define U8_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("uart8e1: same-cycle check failed");
// next-cycle implication
`define U8_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("uart8e1: next-cycle check failed");
`else
`define U8_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define U8_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== hdl/uart8e1_pkg.sv =====
// Shared constants and types for the UART 8E1 unit with receive ring.
package uart8e1_pkg;

	// receive ring geometry
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RX_COUNT_W = 6;

	// serial frame
	localparam int TX_FRAME_BITS = 11;
	localparam logic [15:0] BIT_TICKS_RESET = 16'd16;

	// register index (paddr[2])
	localparam logic REG_BIT_TICKS = 1'b0;

	// command codes
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_POP   = 3'd1;
	localparam logic [2:0] CMD_PEEK  = 3'd2;
	localparam logic [2:0] CMD_FLUSH = 3'd3;
	localparam logic [2:0] CMD_SEND  = 3'd4;

	// receiver to ring control
	typedef struct packed {
		logic       done;
		logic [7:0] data;
	} rx_store_t;

	// transmitter status for this tick
	typedef struct packed {
		logic level;
		logic busy;
	} tx_status_t;

endpackage

// ===== hdl/uart_8e1_with_rx_fifo_unit.sv =====
// Top level: UART 8E1 transceiver with receive ring in RAM and result register.
//
//  channel   handshake                    payload
//  item      item_valid / item_stall      rx_level, cmd, tx_byte
//  result    result_valid / result_stall  tx_level, rx_byte, rx_byte_valid,
//                                         rx_count, overflow_flag, tx_busy
//  config    APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One item per cycle unless stalled; its result appears in the cycle after
// it, with ring data from the RAM's registered port (same-tick store forwarded).
// item_stall is high only while a result is held under result_stall.
// Reset is asynchronous, active low; no clearing pass, ring RAM is not reset.
module uart_8e1_with_rx_fifo_unit (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        rx_level,
	input  logic [2:0]  cmd,
	input  logic [7:0]  tx_byte,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        tx_level,
	output logic [7:0]  rx_byte,
	output logic        rx_byte_valid,
	output logic [5:0]  rx_count,
	output logic        overflow_flag,
	output logic        tx_busy,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "uart_8e1_with_rx_fifo_unit_assert.svh"

	localparam int AW   = uart8e1_pkg::RING_AW;
	localparam int CntW = uart8e1_pkg::RING_AW + 1;
	localparam logic [AW-1:0] RingLast = AW'(uart8e1_pkg::RING_DEPTH - 1);

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		ring_inc = (p == RingLast) ? '0 : p + AW'(1);
	endfunction

	logic [15:0] bit_ticks_q;
	logic [AW-1:0] head_q, tail_q, head_d, tail_d, tail_a, tail_inc;
	logic overflow_q;
	logic accept, we, hit, is_read, fwd;
	logic [CntW-1:0] fill;
	logic [7:0] ram_rdata;
	uart8e1_pkg::rx_store_t  store;
	uart8e1_pkg::tx_status_t tx_st;

	// result register
	logic       valid_s1, tx_level_s1, rx_valid_s1, fwd_s1, overflow_s1, tx_busy_s1;
	logic [7:0] fwd_byte_s1;
	logic [5:0] rx_count_s1;

	// handshake
	assign item_stall = valid_s1 & result_stall;
	assign accept     = item_valid & ~item_stall;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == uart8e1_pkg::REG_BIT_TICKS) ? {16'd0, bit_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= uart8e1_pkg::BIT_TICKS_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == uart8e1_pkg::REG_BIT_TICKS)) begin
			bit_ticks_q <= pwdata[15:0];
		end
	end

	uart8e1_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.rx_level (rx_level),
		.bit_ticks(bit_ticks_q),
		.store    (store)
	);

	uart8e1_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.send     (cmd == uart8e1_pkg::CMD_SEND),
		.tx_byte  (tx_byte),
		.bit_ticks(bit_ticks_q),
		.status   (tx_st)
	);

	// ring control: receiver store first, then pop/peek/flush
	always_comb begin
		tail_inc = ring_inc(tail_q);
		we       = accept && store.done && (tail_inc != head_q);
		tail_a   = we ? tail_inc : tail_q;
		is_read  = (cmd == uart8e1_pkg::CMD_POP) || (cmd == uart8e1_pkg::CMD_PEEK);
		hit      = is_read && (head_q != tail_a);
		fwd      = we && (tail_q == head_q);
		head_d   = head_q;
		tail_d   = tail_a;
		if (cmd == uart8e1_pkg::CMD_FLUSH) begin
			head_d = '0;
			tail_d = '0;
		end else if (hit && (cmd == uart8e1_pkg::CMD_POP)) begin
			head_d = ring_inc(head_q);
		end
		if (tail_d >= head_d) begin
			fill = {1'b0, tail_d} - {1'b0, head_d};
		end else begin
			fill = {1'b0, tail_d} + CntW'(uart8e1_pkg::RING_DEPTH) - {1'b0, head_d};
		end
	end

	uart8e1_ram #(
		.WIDTH(8),
		.DEPTH(uart8e1_pkg::RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (we),
		.waddr(tail_q),
		.wdata(store.data),
		.re   (accept),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// pointers and sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (store.done && !we) begin
				overflow_q <= 1'b1;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			tx_busy_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			tx_busy_s1 <= tx_st.busy;
		end else if (!result_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tx_level_s1 <= tx_st.level;
			rx_valid_s1 <= hit;
			fwd_s1      <= fwd;
			fwd_byte_s1 <= store.data;
			rx_count_s1 <= 6'(fill);
			overflow_s1 <= overflow_q | (store.done & ~we);
		end
	end

	assign result_valid  = valid_s1;
	assign tx_level      = tx_level_s1;
	assign rx_byte_valid = rx_valid_s1;
	assign rx_byte       = rx_valid_s1 ? (fwd_s1 ? fwd_byte_s1 : ram_rdata) : 8'd0;
	assign rx_count      = rx_count_s1;
	assign overflow_flag = overflow_s1;
	assign tx_busy       = tx_busy_s1;

	// checks
	`U8_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, overflow_q, overflow_q)
	`U8_ASSERT_NEXT(a_flush_empty, clk, arst_n, accept && (cmd == uart8e1_pkg::CMD_FLUSH), valid_s1 && (rx_count_s1 == 6'd0) && !rx_valid_s1)
	`U8_ASSERT_NEXT(a_send_busy, clk, arst_n, accept && (cmd == uart8e1_pkg::CMD_SEND), valid_s1 && tx_busy_s1)
	`U8_ASSERT_IMPLY(a_stall_held, clk, arst_n, item_stall, valid_s1 && !accept)

endmodule

// ===== hdl/uart8e1_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module uart8e1_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/uart8e1_rx.sv =====
// UART receiver: start detect, half-bit centering, 8 data samples, tail skip.
module uart8e1_rx (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   rx_level,
	input  logic [15:0]            bit_ticks,
	output uart8e1_pkg::rx_store_t store
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HALF = 4'b0010,
		PH_DATA = 4'b0100,
		PH_TAIL = 4'b1000
	} rx_phase_t;

	rx_phase_t   phase_q, phase_d;
	logic [16:0] cnt_q, cnt_d, cnt_inc;
	logic [2:0]  idx_q, idx_d;
	logic [7:0]  shift_q, shift_d;
	logic        done;

	assign cnt_inc = cnt_q + 17'd1;

	// next-state logic for one tick
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		done    = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (!rx_level) begin
					phase_d = PH_HALF;
					cnt_d   = 17'd0;
				end
			end
			PH_HALF: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= {2'b00, bit_ticks[15:1]}) begin
					phase_d = PH_DATA;
					cnt_d   = 17'd0;
					idx_d   = 3'd0;
				end
			end
			PH_DATA: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= {1'b0, bit_ticks}) begin
					shift_d[idx_q] = rx_level;
					cnt_d          = 17'd0;
					if (idx_q == 3'd7) begin
						phase_d = PH_TAIL;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			PH_TAIL: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= {bit_ticks, 1'b0}) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
					cnt_d   = 17'd0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				cnt_d   = 17'd0;
			end
		endcase
	end

	assign store.done = done;
	assign store.data = shift_q;

	// state registers advance once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 17'd0;
			idx_q   <= 3'd0;
			shift_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
		end
	end

endmodule

// ===== hdl/uart8e1_tx.sv =====
// UART transmitter: 8E1 frame shifter with bit timer.
module uart8e1_tx (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    send,
	input  logic [7:0]              tx_byte,
	input  logic [15:0]             bit_ticks,
	output uart8e1_pkg::tx_status_t status
);

	logic [uart8e1_pkg::TX_FRAME_BITS-1:0] shift_q, shift_d, shift_a;
	logic [15:0] cnt_q, cnt_d, cnt_a, cnt_inc;
	logic [3:0]  left_q, left_d, left_a;
	logic        busy;

	// load a frame when idle, then drive and time the current bit
	always_comb begin
		shift_a = shift_q;
		cnt_a   = cnt_q;
		left_a  = left_q;
		if (send && (left_q == 4'd0)) begin
			shift_a = {1'b1, ^tx_byte, tx_byte, 1'b0};
			left_a  = 4'(uart8e1_pkg::TX_FRAME_BITS);
			cnt_a   = 16'd0;
		end
		busy    = (left_a != 4'd0);
		cnt_inc = cnt_a + 16'd1;
		shift_d = shift_a;
		cnt_d   = cnt_a;
		left_d  = left_a;
		if (busy) begin
			cnt_d = cnt_inc;
			if (cnt_inc >= bit_ticks) begin
				cnt_d   = 16'd0;
				shift_d = {1'b1, shift_a[uart8e1_pkg::TX_FRAME_BITS-1:1]};
				left_d  = left_a - 4'd1;
			end
		end
	end

	assign status.busy  = busy;
	assign status.level = busy ? shift_a[0] : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '1;
			cnt_q   <= 16'd0;
			left_q  <= 4'd0;
		end else if (step) begin
			shift_q <= shift_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench for the UART 8E1 transceiver with receive ring: tick-level prediction and checking.
module tb;

	// unused command codes start here; the block treats them as no command
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [3:0] {
		RX_IDLE = 4'b0001,
		RX_HALF = 4'b0010,
		RX_DATA = 4'b0100,
		RX_TAIL = 4'b1000
	} rx_phase_t;

	typedef struct packed {
		logic       tx_level;
		logic [7:0] rx_byte;
		logic       rx_byte_valid;
		logic [5:0] rx_count;
		logic       overflow_flag;
		logic       tx_busy;
	} tick_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        rx_level;
	logic [2:0]  cmd;
	logic [7:0]  tx_byte;
	logic        result_valid;
	logic        result_stall;
	logic        tx_level;
	logic [7:0]  rx_byte;
	logic        rx_byte_valid;
	logic [5:0]  rx_count;
	logic        overflow_flag;
	logic        tx_busy;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predicted line state
	int          bit_len = uart8e1_pkg::BIT_TICKS_RESET;
	logic [7:0]  ring_mem [uart8e1_pkg::RING_DEPTH];
	int          rd_ptr = 0;
	int          wr_ptr = 0;
	logic        ovf_sticky = 1'b0;
	rx_phase_t   rx_state = RX_IDLE;
	int          rx_cnt = 0;
	int          rx_idx = 0;
	logic [7:0]  rx_sr = 8'h00;
	logic [10:0] tx_sr = '1;
	int          tx_cnt = 0;
	int          tx_left = 0;

	tick_result_t line_results[$];
	logic         rx_wave[$];
	int           errors = 0;
	int           cycles = 0;
	int           ticks_sent = 0;
	bit           steady = 1'b0;

	uart_8e1_with_rx_fifo_unit dut (.*);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one tick of the line: receiver first, then command, then transmitter
	function automatic tick_result_t step_uart(input logic lvl, input logic [2:0] c,
			input logic [7:0] b);
		tick_result_t r;
		int nxt;
		r = '0;
		if (rx_state == RX_IDLE) begin
			if (!lvl) begin
				rx_state = RX_HALF;
				rx_cnt = 0;
			end
		end else begin
			rx_cnt = (rx_cnt + 1) & 'h1FFFF;
			unique case (rx_state)
				RX_HALF: begin
					if (rx_cnt >= (bit_len >> 1)) begin
						rx_state = RX_DATA;
						rx_cnt = 0;
						rx_idx = 0;
					end
				end
				RX_DATA: begin
					if (rx_cnt >= bit_len) begin
						rx_sr[rx_idx] = lvl;
						rx_cnt = 0;
						if (rx_idx >= 7)
							rx_state = RX_TAIL;
						else
							rx_idx++;
					end
				end
				default: begin
					// parity and stop times pass unchecked, then store or flag overflow
					if (rx_cnt >= 2 * bit_len) begin
						nxt = (wr_ptr + 1) % uart8e1_pkg::RING_DEPTH;
						if (nxt != rd_ptr) begin
							ring_mem[wr_ptr] = rx_sr;
							wr_ptr = nxt;
						end else begin
							ovf_sticky = 1'b1;
						end
						rx_state = RX_IDLE;
						rx_cnt = 0;
					end
				end
			endcase
		end

		unique case (c)
			uart8e1_pkg::CMD_POP, uart8e1_pkg::CMD_PEEK: begin
				if (rd_ptr != wr_ptr) begin
					r.rx_byte = ring_mem[rd_ptr];
					r.rx_byte_valid = 1'b1;
					if (c == uart8e1_pkg::CMD_POP)
						rd_ptr = (rd_ptr + 1) % uart8e1_pkg::RING_DEPTH;
				end
			end
			uart8e1_pkg::CMD_FLUSH: begin
				rd_ptr = 0;
				wr_ptr = 0;
			end
			uart8e1_pkg::CMD_SEND: begin
				// a send during a frame is dropped
				if (tx_left == 0) begin
					tx_sr = {1'b1, ^b, b, 1'b0};
					tx_left = uart8e1_pkg::TX_FRAME_BITS;
					tx_cnt = 0;
				end
			end
			default: ;
		endcase

		r.tx_busy = (tx_left != 0);
		r.tx_level = r.tx_busy ? tx_sr[0] : 1'b1;
		if (r.tx_busy) begin
			tx_cnt = (tx_cnt + 1) & 'hFFFF;
			if (tx_cnt >= bit_len) begin
				tx_cnt = 0;
				tx_sr = {1'b1, tx_sr[10:1]};
				tx_left--;
			end
		end
		r.rx_count = 6'((wr_ptr + uart8e1_pkg::RING_DEPTH - rd_ptr) % uart8e1_pkg::RING_DEPTH);
		r.overflow_flag = ovf_sticky;
		return r;
	endfunction

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	function automatic logic [2:0] pick_cmd(input int pop_pct, input int flush_pct);
		int r;
		if ($urandom_range(0, 99) < pop_pct)
			return uart8e1_pkg::CMD_POP;
		if ($urandom_range(0, 99) < flush_pct)
			return uart8e1_pkg::CMD_FLUSH;
		r = $urandom_range(0, 99);
		if (r < 55)
			return uart8e1_pkg::CMD_NONE;
		if (r < 72)
			return uart8e1_pkg::CMD_PEEK;
		if (r < 95)
			return uart8e1_pkg::CMD_SEND;
		return CMD_UNUSED_LO + 3'($urandom_range(0, 2));
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// compare each result transfer with the oldest prediction
	always @(negedge clk) begin : result_check
		tick_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (line_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tx_level %0b rx_count %0d",
					$time, tx_level, rx_count);
				errors++;
			end else begin
				want = line_results.pop_front();
				check_field("tx_level", want.tx_level, tx_level);
				check_field("rx_byte", want.rx_byte, rx_byte);
				check_field("rx_byte_valid", want.rx_byte_valid, rx_byte_valid);
				check_field("rx_count", want.rx_count, rx_count);
				check_field("overflow_flag", want.overflow_flag, overflow_flag);
				check_field("tx_busy", want.tx_busy, tx_busy);
			end
		end
	end

	// result side back-pressure
	initial begin : result_stall_gen
		int len;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!steady && arst_n && $urandom_range(0, 99) < 30) begin
				len = idle_len();
				result_stall <= 1'b1;
				repeat (len) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// one tick transfer; returns at the accepting edge
	task automatic send_tick(input logic lvl, input logic [2:0] c, input logic [7:0] b);
		int gap;
		gap = (!steady && $urandom_range(0, 99) >= 65) ? idle_len() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		rx_level <= lvl;
		cmd <= c;
		tx_byte <= b;
		do @(negedge clk); while (item_stall);
		@(posedge clk);
		line_results.push_back(step_uart(lvl, c, b));
		ticks_sent++;
	endtask

	// APB transfer: setup, access, then idle with psel low
	task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {uart8e1_pkg::REG_BIT_TICKS, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_bit_ticks_readback();
		logic [31:0] rd;
		apb_xfer(1'b0, 32'h0, rd);
		if (rd !== 32'(bit_len)) begin
			$display("%0t: bit_ticks readback mismatch, expected %0d, got %0d", $time, bit_len, rd);
			errors++;
		end
	endtask

	// register write only once every pending result is in
	task automatic program_bit_ticks(input int value);
		logic [31:0] rd;
		item_valid <= 1'b0;
		while (line_results.size() != 0) @(posedge clk);
		apb_xfer(1'b1, 32'(value), rd);
		bit_len = value;
		rx_wave.delete();
		check_bit_ticks_readback();
	endtask

	// queue the next stretch of receive line: a frame, a broken frame or noise
	task automatic queue_line_activity(input int bitlen, input int noise_pct);
		logic [10:0] frame;
		logic [7:0]  d;
		logic        lvl;
		int          len, stop_at, idle, i;
		if ($urandom_range(0, 99) < noise_pct) begin
			repeat ($urandom_range(1, 5)) begin
				lvl = 1'($urandom_range(0, 1));
				len = $urandom_range(1, 2 * bitlen);
				repeat (len) rx_wave.push_back(lvl);
			end
		end else begin
			d = 8'($urandom);
			frame = {1'b1, ^d, d, 1'b0};
			// bad parity is not checked by the receiver
			if ($urandom_range(0, 19) == 0)
				frame[9] = ~frame[9];
			// now and then a frame cut short
			stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10)
				: uart8e1_pkg::TX_FRAME_BITS;
			idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, bitlen);
			repeat (idle) rx_wave.push_back(1'b1);
			for (i = 0; i < uart8e1_pkg::TX_FRAME_BITS; i++)
				repeat (bitlen) rx_wave.push_back((i < stop_at) ? frame[i] : 1'b1);
		end
	endtask

	task automatic run_ticks(input int n, input int bitlen, input int noise_pct,
			input int pop_pct, input int flush_pct);
		int k;
		for (k = 0; k < n; k++) begin
			// every fourth stretch of 50 ticks runs without idling
			steady = ((ticks_sent / 50) % 4) == 3;
			if (rx_wave.size() == 0)
				queue_line_activity(bitlen, noise_pct);
			send_tick(rx_wave.pop_front(), pick_cmd(pop_pct, flush_pct), 8'($urandom));
		end
		steady = 1'b0;
	endtask

	// reset value, every command, empty ring, send while busy, unused codes
	task automatic test_commands_directed();
		int i;
		check_bit_ticks_readback();
		send_tick(1'b1, uart8e1_pkg::CMD_NONE, 8'h00);
		send_tick(1'b1, uart8e1_pkg::CMD_POP, 8'h00);
		send_tick(1'b1, uart8e1_pkg::CMD_PEEK, 8'hFF);
		send_tick(1'b1, uart8e1_pkg::CMD_FLUSH, 8'hFF);
		send_tick(1'b1, uart8e1_pkg::CMD_SEND, 8'hFF);
		send_tick(1'b1, uart8e1_pkg::CMD_SEND, 8'h00);
		for (i = 0; i < 3; i++)
			send_tick(1'b1, CMD_UNUSED_LO + 3'(i), (i == 1) ? 8'h55 : 8'hAA);
		for (i = 0; i < 4; i++)
			send_tick(1'b0, uart8e1_pkg::CMD_NONE, 8'h00);
		send_tick(1'b0, uart8e1_pkg::CMD_SEND, 8'h81);
		send_tick(1'b1, uart8e1_pkg::CMD_PEEK, 8'h00);
		send_tick(1'b1, uart8e1_pkg::CMD_POP, 8'h7E);
	endtask

	// frames and noise at several bit rates, changed while frames run
	task automatic test_serial_traffic();
		program_bit_ticks(2);
		run_ticks(170, 2, 15, 20, 2);
		program_bit_ticks(3);
		run_ticks(170, 3, 15, 20, 2);
		program_bit_ticks(4);
		run_ticks(170, 4, 15, 15, 2);
		program_bit_ticks(9);
		run_ticks(170, 9, 15, 15, 2);
	endtask

	// fill the ring without pops until a byte is lost, then drain and flush
	task automatic test_ring_overflow();
		int guard;
		guard = 0;
		program_bit_ticks(1);
		while (!ovf_sticky && guard < 1400) begin
			run_ticks(20, 1, 5, 0, 0);
			guard += 20;
		end
		run_ticks(40, 1, 5, 0, 0);
		run_ticks(120, 1, 10, 40, 3);
	endtask

	task automatic test_minimal_bit_ticks();
		program_bit_ticks(0);
		run_ticks(120, 1, 30, 30, 2);
	endtask

	// largest bit time, then a small one while the long frames are under way
	task automatic test_maximal_bit_ticks();
		program_bit_ticks(65535);
		run_ticks(150, 40, 100, 20, 2);
		program_bit_ticks(2);
		run_ticks(60, 2, 15, 20, 2);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		rx_level = 1'b1;
		cmd = uart8e1_pkg::CMD_NONE;
		tx_byte = 8'h00;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands_directed();
		test_serial_traffic();
		test_ring_overflow();
		test_minimal_bit_ticks();
		test_maximal_bit_ticks();

		// drain outstanding results
		item_valid <= 1'b0;
		while (line_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
